>>> design/iat_pkg.sv
// Shared types and constants for the interval allocation table.
`default_nettype none

package iat_pkg;

    localparam int ADDR_W = 16;
    localparam int END_W  = 17;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERLAP   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_DEALLOC = 1'b1;

    // How a containing entry relates to the range being released.
    typedef enum logic [1:0] {
        KIND_WHOLE = 2'd0,
        KIND_FRONT = 2'd1,
        KIND_END   = 2'd2,
        KIND_SPLIT = 2'd3
    } t_kind;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_size;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entries_used;
    } t_out_beat;

    // Registered request as the cells see it.
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] lo;
        logic [END_W-1:0]  hi;
    } t_req;

    // Summary handed from one cell to the next along the row.
    typedef struct packed {
        logic             ovl;
        logic             hit;
        t_kind            kind;
        logic [END_W-1:0] hit_last;
        logic             free;
    } t_link;

    // Table update broadcast to every cell.
    typedef struct packed {
        logic             wr_new;
        logic             rm;
        logic             trim_front;
        logic             trim_end;
        logic             cut;
        logic [END_W-1:0] new_first;
        logic [END_W-1:0] new_last;
    } t_cmd;

endpackage

`default_nettype wire

>>> design/iat_cell.sv
// One table entry: holds a range, compares it with the request and chains its result on.
`default_nettype none

module iat_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire iat_pkg::t_req  i_req,
    input  wire iat_pkg::t_link i_link,
    output iat_pkg::t_link      o_link,
    input  wire iat_pkg::t_cmd  i_cmd
);

    logic                        r_valid;
    logic [iat_pkg::END_W-1:0]   r_first;
    logic [iat_pkg::END_W-1:0]   r_last;

    logic [iat_pkg::END_W-1:0]   lo_ext;
    logic                        ovl;
    logic                        contain;
    logic                        free;
    logic                        sel_hit;
    logic                        sel_free;
    iat_pkg::t_kind              kind;

    assign lo_ext  = {1'b0, i_req.lo};
    assign ovl     = r_valid && (r_first <= i_req.hi) && (r_last >= lo_ext);
    assign contain = r_valid && (r_first <= lo_ext) && (r_last >= i_req.hi);
    assign free    = !r_valid;

    always_comb begin
        if (r_first == lo_ext && r_last == i_req.hi) begin
            kind = iat_pkg::KIND_WHOLE;
        end else if (r_first == lo_ext) begin
            kind = iat_pkg::KIND_FRONT;
        end else if (r_last == i_req.hi) begin
            kind = iat_pkg::KIND_END;
        end else begin
            kind = iat_pkg::KIND_SPLIT;
        end
    end

    // Only the lowest containing entry and the lowest free entry are selected.
    assign sel_hit  = contain && !i_link.hit;
    assign sel_free = free && !i_link.free;

    always_comb begin
        o_link.ovl      = i_link.ovl | ovl;
        o_link.hit      = i_link.hit | contain;
        o_link.kind     = i_link.hit ? i_link.kind : kind;
        o_link.hit_last = i_link.hit ? i_link.hit_last : r_last;
        o_link.free     = i_link.free | free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr_new && sel_free) begin
            r_valid <= 1'b1;
        end else if (i_cmd.rm && sel_hit) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new && sel_free) begin
            r_first <= i_cmd.new_first;
            r_last  <= i_cmd.new_last;
        end else if (sel_hit) begin
            if (i_cmd.trim_front) begin
                r_first <= i_req.hi;
            end
            if (i_cmd.trim_end) begin
                r_last <= lo_ext;
            end
            if (i_cmd.cut) begin
                r_last <= lo_ext - {{(iat_pkg::END_W-1){1'b0}}, 1'b1};
            end
        end
    end

endmodule

`default_nettype wire

>>> design/interval_allocation_table_unit.sv
// Interval allocation table: a row of entry cells and the request controller.
//
// The input channel carries one request per beat: mode (allocate or
// deallocate), range_start and range_size; the range ends at start plus size
// and both ends belong to it. The output channel returns one beat per
// request with a status and the number of entries in use afterwards.
// A request is first accepted and registered; then every cell compares its
// entry with the request, the cells pass overlap, containment and
// free-slot flags down the row to pick the lowest matching entry, and the
// table is updated. The length of that cell row sets the evaluation path.
// A new request is accepted once the previous one has been evaluated, so
// the block never holds more than one request in evaluation.
// The result sits in an output register; while the receiver stalls, the
// next request is still accepted but waits in evaluation until the output
// register is free. Reset clears every entry valid flag, the use count and
// both channels; the stored range bounds need no reset.
`default_nettype none

module interval_allocation_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire iat_pkg::t_in_beat i_in_beat,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output iat_pkg::t_out_beat     o_out_beat
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state              r_state;
    t_state              n_state;
    iat_pkg::t_req       r_req;
    logic [CW-1:0]       r_used;
    logic [CW-1:0]       n_used;
    logic                r_out_valid;
    iat_pkg::t_out_beat  r_out;

    iat_pkg::t_link      links [TABLE_DEPTH+1];
    iat_pkg::t_link      tail;
    iat_pkg::t_cmd       cmd_raw;
    iat_pkg::t_cmd       cmd;
    iat_pkg::t_status    status;
    logic                out_free;
    logic                go;
    logic                accept;

    assign links[0] = '0;
    assign tail     = links[TABLE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            iat_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_req   (r_req),
                .i_link  (links[g]),
                .o_link  (links[g+1]),
                .i_cmd   (cmd)
            );
        end
    endgenerate

    assign out_free   = !r_out_valid || !i_out_stall;
    assign go         = (r_state == S_EVAL) && out_free;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        cmd_raw = '0;
        status  = iat_pkg::ST_DONE;
        if (r_req.mode == iat_pkg::MODE_ALLOC) begin
            if (tail.ovl) begin
                status = iat_pkg::ST_OVERLAP;
            end else if (!tail.free) begin
                status = iat_pkg::ST_FULL;
            end else begin
                cmd_raw.wr_new    = 1'b1;
                cmd_raw.new_first = {1'b0, r_req.lo};
                cmd_raw.new_last  = r_req.hi;
            end
        end else if (!tail.hit) begin
            status = iat_pkg::ST_NOT_FOUND;
        end else begin
            unique case (tail.kind)
                iat_pkg::KIND_WHOLE: cmd_raw.rm         = 1'b1;
                iat_pkg::KIND_FRONT: cmd_raw.trim_front = 1'b1;
                iat_pkg::KIND_END:   cmd_raw.trim_end   = 1'b1;
                iat_pkg::KIND_SPLIT: begin
                    if (!tail.free) begin
                        status = iat_pkg::ST_FULL;
                    end else begin
                        // The right part goes to the lowest free entry.
                        cmd_raw.cut       = 1'b1;
                        cmd_raw.wr_new    = 1'b1;
                        cmd_raw.new_first = r_req.hi;
                        cmd_raw.new_last  = tail.hit_last;
                    end
                end
                default: cmd_raw = '0;
            endcase
        end
    end

    assign cmd    = go ? cmd_raw : '0;
    assign n_used = r_used + CW'(cmd.wr_new) - CW'(cmd.rm);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EVAL;
            S_EVAL: if (go)     n_state = S_IDLE;
            default:            n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.mode <= i_in_beat.mode;
            r_req.lo   <= i_in_beat.range_start;
            r_req.hi   <= {1'b0, i_in_beat.range_start} + {1'b0, i_in_beat.range_size};
        end
        if (go) begin
            r_out.status       <= status;
            r_out.entries_used <= 5'(n_used);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the interval allocation table unit.
module tb_top;

    localparam int DEPTH        = 16;
    localparam int RANDOM_BEATS = 800;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_START    = 65535;

    typedef struct {
        logic             mode;
        int               start;
        int               size;
        int               rep;
        int               step;
        bit               has_want;
        iat_pkg::t_status want_status;
        int               want_used;
    } t_dir_row;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               in_valid   = 1'b0;
    logic               out_stall  = 1'b0;
    iat_pkg::t_in_beat  in_beat    = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    iat_pkg::t_out_beat o_out_beat;

    // Copy of the table as the block should hold it.
    logic [iat_pkg::END_W-1:0] tbl_first [DEPTH];
    logic [iat_pkg::END_W-1:0] tbl_last  [DEPTH];
    logic                      tbl_live  [DEPTH];

    iat_pkg::t_out_beat expected_results [$];
    int                 error_count   = 0;
    int                 send_idle_pct = 14;
    int                 stall_pct     = 80;

    t_dir_row directed_rows [0:20] = '{
        '{iat_pkg::MODE_DEALLOC,     0,     0,  1,  0, 1'b1, iat_pkg::ST_NOT_FOUND,  0},
        '{iat_pkg::MODE_ALLOC,       0,     0,  1,  0, 1'b1, iat_pkg::ST_DONE,       1},
        '{iat_pkg::MODE_ALLOC,       0,     0,  1,  0, 1'b1, iat_pkg::ST_OVERLAP,    1},
        '{iat_pkg::MODE_DEALLOC,     0,     0,  1,  0, 1'b1, iat_pkg::ST_DONE,       0},
        '{iat_pkg::MODE_ALLOC,     100,    50,  1,  0, 1'b1, iat_pkg::ST_DONE,       1},
        '{iat_pkg::MODE_ALLOC,     150,    10,  1,  0, 1'b1, iat_pkg::ST_OVERLAP,    1},
        '{iat_pkg::MODE_ALLOC,      90,    10,  1,  0, 1'b1, iat_pkg::ST_OVERLAP,    1},
        '{iat_pkg::MODE_ALLOC,     151,     4,  1,  0, 1'b1, iat_pkg::ST_DONE,       2},
        '{iat_pkg::MODE_DEALLOC,   100,    10,  1,  0, 1'b1, iat_pkg::ST_DONE,       2},
        '{iat_pkg::MODE_DEALLOC,   140,    10,  1,  0, 1'b1, iat_pkg::ST_DONE,       2},
        '{iat_pkg::MODE_DEALLOC,   120,     5,  1,  0, 1'b1, iat_pkg::ST_DONE,       3},
        '{iat_pkg::MODE_DEALLOC,   200,     0,  1,  0, 1'b1, iat_pkg::ST_NOT_FOUND,  3},
        '{iat_pkg::MODE_DEALLOC,   105,    10,  1,  0, 1'b1, iat_pkg::ST_NOT_FOUND,  3},
        '{iat_pkg::MODE_ALLOC,   65535, 65535,  1,  0, 1'b1, iat_pkg::ST_DONE,       4},
        '{iat_pkg::MODE_DEALLOC, 65535,    10,  1,  0, 1'b1, iat_pkg::ST_DONE,       4},
        '{iat_pkg::MODE_DEALLOC, 65535, 65535,  1,  0, 1'b1, iat_pkg::ST_NOT_FOUND,  4},
        '{iat_pkg::MODE_ALLOC,    1000,     5, 13, 10, 1'b0, iat_pkg::ST_DONE,       0},
        '{iat_pkg::MODE_ALLOC,    5000,     0,  1,  0, 1'b1, iat_pkg::ST_FULL,      16},
        '{iat_pkg::MODE_ALLOC,    1000,     0,  1,  0, 1'b1, iat_pkg::ST_OVERLAP,   16},
        '{iat_pkg::MODE_DEALLOC,  1001,     1,  1,  0, 1'b1, iat_pkg::ST_FULL,      16},
        '{iat_pkg::MODE_DEALLOC,  1000,     5,  1,  0, 1'b1, iat_pkg::ST_DONE,      15}
    };

    interval_allocation_table_unit #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the table copy and returns the beat it should produce.
    function automatic iat_pkg::t_out_beat apply_request(iat_pkg::t_in_beat b);
        logic [iat_pkg::END_W-1:0] lo;
        logic [iat_pkg::END_W-1:0] hi;
        iat_pkg::t_status          st;
        int                        i;
        int                        hit;
        int                        slot;
        int                        used;
        iat_pkg::t_out_beat        r;
        lo   = {1'b0, b.range_start};
        hi   = lo + {1'b0, b.range_size};
        hit  = -1;
        slot = -1;
        used = 0;
        for (i = DEPTH - 1; i >= 0; i--) begin
            if (!tbl_live[i]) slot = i;
        end
        if (b.mode == iat_pkg::MODE_ALLOC) begin
            st = iat_pkg::ST_DONE;
            for (i = 0; i < DEPTH; i++) begin
                if (tbl_live[i] && tbl_first[i] <= hi && tbl_last[i] >= lo) begin
                    st = iat_pkg::ST_OVERLAP;
                end
            end
            if (st == iat_pkg::ST_DONE) begin
                if (slot < 0) begin
                    st = iat_pkg::ST_FULL;
                end else begin
                    tbl_first[slot] = lo;
                    tbl_last[slot]  = hi;
                    tbl_live[slot]  = 1'b1;
                end
            end
        end else begin
            for (i = DEPTH - 1; i >= 0; i--) begin
                if (tbl_live[i] && tbl_first[i] <= lo && tbl_last[i] >= hi) hit = i;
            end
            if (hit < 0) begin
                st = iat_pkg::ST_NOT_FOUND;
            end else begin
                st = iat_pkg::ST_DONE;
                if (tbl_first[hit] == lo && tbl_last[hit] == hi) begin
                    tbl_live[hit] = 1'b0;
                end else if (tbl_first[hit] == lo) begin
                    tbl_first[hit] = hi;
                end else if (tbl_last[hit] == hi) begin
                    tbl_last[hit] = lo;
                end else if (slot < 0) begin
                    st = iat_pkg::ST_FULL;
                end else begin
                    // The right part moves to a free entry; the left part keeps the old one.
                    tbl_first[slot] = hi;
                    tbl_last[slot]  = tbl_last[hit];
                    tbl_live[slot]  = 1'b1;
                    tbl_last[hit]   = lo - 1'b1;
                end
            end
        end
        for (i = 0; i < DEPTH; i++) begin
            if (tbl_live[i]) used++;
        end
        r.status       = st;
        r.entries_used = used[4:0];
        return r;
    endfunction

    // Allocations mostly fall into a few crowded windows so that overlaps and a full table occur.
    function automatic iat_pkg::t_in_beat make_claim();
        int                pick;
        int                base;
        iat_pkg::t_in_beat b;
        pick          = $urandom_range(0, 99);
        b.mode        = iat_pkg::MODE_ALLOC;
        b.range_start = 16'($urandom);
        b.range_size  = 16'($urandom);
        if (pick < 70) begin
            case ($urandom_range(0, 2))
                0:       base = 0;
                1:       base = 20000;
                default: base = 62000;
            endcase
            b.range_start = 16'(base + int'($urandom_range(0, 3000)));
            b.range_size  = 16'($urandom_range(0, 200));
        end else if (pick < 85) begin
            b.range_start = 16'($urandom_range(60000, MAX_START));
        end
        return b;
    endfunction

    // Releases usually cut a piece out of a live entry: all of it, its front, its end or its middle.
    function automatic iat_pkg::t_in_beat make_release();
        int                cand [$];
        int                i;
        int                k;
        int                f;
        int                l;
        int                top;
        int                lo;
        int                sz;
        iat_pkg::t_in_beat b;
        b.mode        = iat_pkg::MODE_DEALLOC;
        b.range_start = 16'($urandom);
        b.range_size  = 16'($urandom);
        for (i = 0; i < DEPTH; i++) begin
            if (tbl_live[i] && tbl_first[i] <= MAX_START) cand.push_back(i);
        end
        if (cand.size() == 0 || $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                b.range_start = 16'($urandom_range(0, 3200));
                b.range_size  = 16'($urandom_range(0, 100));
            end
            return b;
        end
        k   = cand[$urandom_range(0, cand.size() - 1)];
        f   = int'(tbl_first[k]);
        l   = int'(tbl_last[k]);
        top = (l > MAX_START) ? MAX_START : l;
        case ($urandom_range(0, 3))
            0: begin
                lo = f;
                sz = l - f;
            end
            1: begin
                lo = f;
                sz = int'($urandom_range(0, l - f));
            end
            2: begin
                lo = int'($urandom_range(f, top));
                sz = l - lo;
            end
            default: begin
                lo = int'($urandom_range(f, top));
                sz = int'($urandom_range(0, l - lo));
            end
        endcase
        b.range_start = 16'(lo);
        b.range_size  = 16'(sz);
        return b;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic send_request(iat_pkg::t_in_beat b, bit has_want, iat_pkg::t_out_beat want);
        iat_pkg::t_out_beat predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_request(b);
        expected_results.push_back(has_want ? want : predicted);
    endtask

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        iat_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("beat with nothing pending, status",
                                int'(o_out_beat.status), -1);
            end else begin
                want = expected_results.pop_front();
                if (o_out_beat.status !== want.status)
                    report_mismatch("status", int'(o_out_beat.status), int'(want.status));
                if (o_out_beat.entries_used !== want.entries_used)
                    report_mismatch("entries_used", int'(o_out_beat.entries_used),
                                    int'(want.entries_used));
            end
        end
    end

    initial begin
        int                 r;
        int                 j;
        int                 n;
        iat_pkg::t_in_beat  b;
        iat_pkg::t_out_beat want;
        for (r = 0; r < DEPTH; r++) begin
            tbl_first[r] = '0;
            tbl_last[r]  = '0;
            tbl_live[r]  = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < $size(directed_rows); r++) begin
            for (j = 0; j < directed_rows[r].rep; j++) begin
                b.mode            = directed_rows[r].mode;
                b.range_start     = 16'(directed_rows[r].start + j * directed_rows[r].step);
                b.range_size      = 16'(directed_rows[r].size);
                want.status       = directed_rows[r].want_status;
                want.entries_used = 5'(directed_rows[r].want_used);
                send_request(b, directed_rows[r].has_want, want);
            end
        end

        // Three stretches: slow receiver, then slow sender, then no idling at all.
        for (n = 0; n < RANDOM_BEATS; n++) begin
            case (n * 3 / RANDOM_BEATS)
                0: begin
                    send_idle_pct = 14;
                    stall_pct     = 80;
                end
                1: begin
                    send_idle_pct = 80;
                    stall_pct     = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            b = ($urandom_range(0, 1) == 0) ? make_claim() : make_release();
            send_request(b, 1'b0, want);
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
design/iat_pkg.sv
design/iat_cell.sv
design/interval_allocation_table_unit.sv
tb/sv/tb_top.sv
